// ===== sv/cpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and codes for the cradle pulse-pattern detector: cradle kinds,
// pattern classes, command codes, register map and inter-module structures.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int WIN_W  = 16;
    localparam int THR_W  = 15;
    localparam int IN_W   = 8;
    localparam int OUT_W  = 16;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE  = 2'd0;
    localparam kind_t KIND_BASIC = 2'd1;
    localparam kind_t KIND_SMART = 2'd2;

    typedef logic [1:0] pat_t;
    localparam pat_t PAT_NONE  = 2'd0;
    localparam pat_t PAT_LOW   = 2'd1;
    localparam pat_t PAT_HIGH  = 2'd2;
    localparam pat_t PAT_SMART = 2'd3;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_KEEP   = 2'd0;
    localparam cmd_t CMD_CLEAR  = 2'd1;
    localparam cmd_t CMD_SET    = 2'd2;

    typedef logic [2:0] dstate_t;
    localparam dstate_t ST_DOCK  = 3'b001;
    localparam dstate_t ST_IGN   = 3'b010;
    localparam dstate_t ST_SMART = 3'b100;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_WINDOW    = 3'd0;
    localparam reg_idx_t REG_LOW_MIN   = 3'd1;
    localparam reg_idx_t REG_LOW_MAX   = 3'd2;
    localparam reg_idx_t REG_HIGH_MAX  = 3'd3;
    localparam reg_idx_t REG_DOCK_LVL  = 3'd4;
    localparam reg_idx_t REG_IGN_LVL   = 3'd5;

    typedef struct packed {
        logic [WIN_W-1:0] window_samples;
        logic [THR_W-1:0] low_min_pulses;
        logic [THR_W-1:0] low_max_pulses;
        logic [THR_W-1:0] high_max_pulses;
        logic             dock_active_level;
        logic             ign_active_level;
    } cfg_t;

    typedef struct packed {
        logic ign_level;
        logic dock_level;
        logic start_request;
    } sample_t;

    typedef struct packed {
        logic fire;
        pat_t pat;
        logic ign;
        logic dock;
    } win_t;

    typedef struct packed {
        logic    wake_hold;
        cmd_t    speaker_pin_command;
        cmd_t    usb_switch_command;
        cmd_t    charge_command;
        pat_t    pattern_class;
        kind_t   cradle_kind;
        logic    state_changed;
        dstate_t dock_state;
    } result_t;

endpackage

// ===== sv/cpd_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_cfg
// APB register file holding the window length, pulse thresholds and the
// active levels of the dock and ignition pins.
// ----------------------------------------------------------------------------
module cpd_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cpd_pkg::ADDR_W-1:0] paddr,
    input  logic [cpd_pkg::DATA_W-1:0] pwdata,
    output logic [cpd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output cpd_pkg::cfg_t              cfg
);
    import cpd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_WINDOW:   cfg_next.window_samples    = pwdata[WIN_W-1:0];
                REG_LOW_MIN:  cfg_next.low_min_pulses    = pwdata[THR_W-1:0];
                REG_LOW_MAX:  cfg_next.low_max_pulses    = pwdata[THR_W-1:0];
                REG_HIGH_MAX: cfg_next.high_max_pulses   = pwdata[THR_W-1:0];
                REG_DOCK_LVL: cfg_next.dock_active_level = pwdata[0];
                REG_IGN_LVL:  cfg_next.ign_active_level  = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_WINDOW:   prdata = {{(DATA_W-WIN_W){1'b0}}, cfg_reg.window_samples};
            REG_LOW_MIN:  prdata = {{(DATA_W-THR_W){1'b0}}, cfg_reg.low_min_pulses};
            REG_LOW_MAX:  prdata = {{(DATA_W-THR_W){1'b0}}, cfg_reg.low_max_pulses};
            REG_HIGH_MAX: prdata = {{(DATA_W-THR_W){1'b0}}, cfg_reg.high_max_pulses};
            REG_DOCK_LVL: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.dock_active_level};
            REG_IGN_LVL:  prdata = {{(DATA_W-1){1'b0}}, cfg_reg.ign_active_level};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_samples    <= WIN_W'(30000);
            cfg_reg.low_min_pulses    <= THR_W'(8);
            cfg_reg.low_max_pulses    <= THR_W'(30);
            cfg_reg.high_max_pulses   <= THR_W'(75);
            cfg_reg.dock_active_level <= 1'b0;
            cfg_reg.ign_active_level  <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/cpd_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_window
// Trigger detection and the measuring window: counts ignition transitions,
// halves them into pulses and classes the pulse count when the window closes.
// ----------------------------------------------------------------------------
module cpd_window
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  cpd_pkg::sample_t smp,
    input  cpd_pkg::cfg_t   cfg,
    input  cpd_pkg::kind_t  kind,
    output cpd_pkg::win_t   win
);
    import cpd_pkg::*;

    localparam int PW = (COUNT_BITS - 1 > THR_W) ? COUNT_BITS - 1 : THR_W;

    logic                  measuring_reg, measuring_next;
    logic [WIN_W-1:0]      wcount_reg, wcount_next;
    logic [COUNT_BITS-1:0] tcount_reg, tcount_next;
    logic                  tracked_reg, tracked_next;
    logic [1:0]            prev_reg;

    logic                  trig;
    logic                  active;
    logic [WIN_W-1:0]      wcount_cur;
    logic [COUNT_BITS-1:0] tcount_cur;
    logic                  tracked_cur;
    logic [WIN_W-1:0]      limit;
    logic [PW-1:0]         pulses;
    logic                  close;
    pat_t                  pat;

    assign trig = smp.start_request || (smp.ign_level != prev_reg[0]) ||
                  ((smp.dock_level != prev_reg[1]) && (kind != KIND_SMART));
    assign limit = (cfg.window_samples == '0) ? WIN_W'(1) : cfg.window_samples;

    always_comb
    begin
        active      = measuring_reg || (trig && (kind != KIND_BASIC));
        wcount_cur  = measuring_reg ? wcount_reg  : '0;
        tcount_cur  = measuring_reg ? tcount_reg  : '0;
        tracked_cur = measuring_reg ? tracked_reg : 1'b0;

        tracked_next = tracked_cur;
        tcount_next  = tcount_cur;
        if (smp.ign_level != tracked_cur)
        begin
            tracked_next = smp.ign_level;
            if (tcount_cur != '1)
            begin
                tcount_next = tcount_cur + COUNT_BITS'(1);
            end
        end
        wcount_next = wcount_cur + WIN_W'(1);
        close       = active && (wcount_next >= limit);

        pulses = PW'(tcount_next >> 1);
        if (pulses < PW'(cfg.low_min_pulses))
        begin
            pat = PAT_NONE;
        end
        else if (pulses <= PW'(cfg.low_max_pulses))
        begin
            pat = PAT_LOW;
        end
        else if (pulses <= PW'(cfg.high_max_pulses))
        begin
            pat = PAT_HIGH;
        end
        else
        begin
            pat = PAT_SMART;
        end

        measuring_next = active && !close;

        win.ign  = smp.ign_level;
        win.dock = smp.dock_level;
        if (!measuring_reg && trig && (kind == KIND_BASIC))
        begin
            win.fire = 1'b1;
            win.pat  = PAT_NONE;
        end
        else
        begin
            win.fire = close;
            win.pat  = pat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measuring_reg <= 1'b0;
            wcount_reg    <= '0;
            tcount_reg    <= '0;
            tracked_reg   <= 1'b0;
            prev_reg      <= '0;
        end
        else if (step)
        begin
            prev_reg      <= {smp.dock_level, smp.ign_level};
            measuring_reg <= measuring_next;
            if (active)
            begin
                wcount_reg  <= wcount_next;
                tcount_reg  <= tcount_next;
                tracked_reg <= tracked_next;
            end
        end
    end

endmodule

// ===== sv/cpd_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_eval
// Cradle-kind state machine: updates the dock state from the pattern class
// and pin levels and issues the charge, USB-switch, speaker and wake commands.
// ----------------------------------------------------------------------------
module cpd_eval
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  cpd_pkg::win_t   win,
    input  cpd_pkg::cfg_t   cfg,
    output cpd_pkg::kind_t  kind,
    output cpd_pkg::result_t res
);
    import cpd_pkg::*;

    kind_t   kind_reg, kind_next;
    dstate_t rep_reg;
    dstate_t val;
    cmd_t    charge, usb, spk;
    logic    dock_on, ign_on, act;

    assign kind = kind_reg;

    always_comb
    begin
        dock_on   = (win.dock == cfg.dock_active_level);
        ign_on    = (win.ign == cfg.ign_active_level);
        kind_next = kind_reg;
        val       = '0;
        charge    = CMD_KEEP;
        usb       = CMD_KEEP;
        spk       = CMD_KEEP;
        act       = 1'b0;

        if (kind_reg != KIND_BASIC)
        begin
            if (win.pat == PAT_NONE)
            begin
                if (kind_reg == KIND_SMART && !ign_on)
                begin
                    charge    = CMD_CLEAR;
                    kind_next = KIND_NONE;
                    act       = 1'b1;
                end
                else if (kind_reg != KIND_SMART && dock_on)
                begin
                    kind_next = KIND_BASIC;
                    act       = 1'b1;
                end
                if (act)
                begin
                    spk = CMD_CLEAR;
                    usb = dock_on ? CMD_SET : CMD_CLEAR;
                end
                else
                begin
                    val = rep_reg;
                end
            end
            else if (kind_reg == KIND_SMART)
            begin
                if (win.pat == PAT_HIGH)
                begin
                    val = ST_DOCK | ST_IGN | ST_SMART;
                end
                else if (win.pat == PAT_LOW)
                begin
                    val = ST_DOCK | ST_SMART;
                end
                else
                begin
                    val = rep_reg;
                end
            end
            else
            begin
                kind_next = KIND_SMART;
                charge    = CMD_SET;
                val       = (win.pat == PAT_HIGH) ? (ST_DOCK | ST_IGN | ST_SMART)
                                                  : (ST_DOCK | ST_SMART);
                spk       = CMD_SET;
                usb       = cfg.dock_active_level ? CMD_SET : CMD_CLEAR;
            end
        end

        if (kind_next == KIND_BASIC)
        begin
            if (dock_on)
            begin
                val = val | ST_DOCK;
            end
            else
            begin
                kind_next = KIND_NONE;
            end
            if (ign_on)
            begin
                val = val | ST_IGN;
            end
        end

        res.dock_state          = val;
        res.state_changed       = (val != rep_reg);
        res.cradle_kind         = kind_next;
        res.pattern_class       = win.pat;
        res.charge_command      = charge;
        res.usb_switch_command  = usb;
        res.speaker_pin_command = spk;
        res.wake_hold           = val[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_NONE;
            rep_reg  <= '0;
        end
        else if (step && win.fire)
        begin
            kind_reg <= kind_next;
            rep_reg  <= val;
        end
    end

endmodule

// ===== sv/cradle_pulse_pattern_detector.sv =====
`timescale 1ns / 1ps
// A sample enters the input register; a result it yields is offered from the result register.
// Throughput: one beat per cycle unless m_axis_tready stalls; each register holds one beat.
// A sample that causes no result simply passes through the input register.
// Reset (rst_n low) clears the window, the cradle state and both valid flags at once.
// ----------------------------------------------------------------------------
// cradle_pulse_pattern_detector
// Samples the ignition and dock pins, measures ignition pulse patterns over a
// window and reports cradle state changes with the matching commands.
// ----------------------------------------------------------------------------
module cradle_pulse_pattern_detector
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // Bit 0 ign_level, bit 1 dock_level, bit 2 start_request, rest zero.
    input  logic [cpd_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // dock_state[2:0], state_changed[3], cradle_kind[5:4], pattern_class[7:6],
    // charge_command[9:8], usb_switch_command[11:10],
    // speaker_pin_command[13:12], wake_hold[14], bit 15 zero.
    output logic [cpd_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cpd_pkg::ADDR_W-1:0] paddr,
    input  logic [cpd_pkg::DATA_W-1:0] pwdata,
    output logic [cpd_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import cpd_pkg::*;

    cfg_t    cfg;
    sample_t smp_reg;
    logic    in_valid_reg;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    step;
    win_t    win;
    kind_t   kind;
    result_t res;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg};

    cpd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpd_window #(.COUNT_BITS(COUNT_BITS)) u_window
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .smp   (smp_reg),
        .cfg   (cfg),
        .kind  (kind),
        .win   (win)
    );

    cpd_eval u_eval
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .win   (win),
        .cfg   (cfg),
        .kind  (kind),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= step && win.fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            smp_reg.ign_level     <= s_axis_tdata[0];
            smp_reg.dock_level    <= s_axis_tdata[1];
            smp_reg.start_request <= s_axis_tdata[2];
        end
        if (step && win.fire)
        begin
            res_reg <= res;
        end
    end

endmodule
